FILE: sv/utcs_pkg.sv
package utcs_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the accepted byte into the character buffer
    logic step;    // one emission or drop for the front character
    logic finish;  // close the step: release held byte, end marker, clear on last
  } utcs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic more;     // the buffer still holds a character to resolve
    logic step_ok;  // the pending step can go ahead this cycle
    logic fin_ok;   // the closing action can go ahead this cycle
  } utcs_stat_t;

endpackage

FILE: sv/utf8_text_clean_cjk_spacer_unit.sv
// One input byte per request; the byte is loaded, then each step emits one byte or drops
// a character, and a closing action ends the request; receiver stalls can hold a step.
// Throughput is set by the single emission sequencer: at most one result byte per cycle.
// in_ready is registered and is high only while idle, so a new request waits for the close;
// each byte is held until the next one or the close of its step, so out_last marks the last.
// Reset (rst_n, synchronous, active low) empties the buffer and output, sets both modes to 1.
module utf8_text_clean_cjk_spacer_unit
  import utcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_last
);

  utcs_cmd_t  cmd;
  utcs_stat_t stat;

  // sequencing
  utcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // buffer, decode and output
  utcs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_last         (out_last)
  );

endmodule

FILE: sv/utcs_ctrl.sv
module utcs_ctrl
  import utcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  utcs_stat_t stat,
  output utcs_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // command decode
  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_ready_r && in_valid;
    cmd.step   = (state_r == ST_PROC) && stat.more && stat.step_ok;
    cmd.finish = (state_r == ST_PROC) && !stat.more && stat.fin_ok;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_PROC;
      end
      ST_PROC: begin
        if (cmd.finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

FILE: sv/utcs_dp.sv
module utcs_dp
  import utcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  utcs_cmd_t  cmd,
  output utcs_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_last
);

  localparam logic REG_CLEAN = 1'b0;
  localparam logic REG_CJK   = 1'b1;

  localparam logic [7:0] SPACE = 8'h20;

  // config
  logic clean_r, cjk_r;

  // character buffer and sequencing
  logic [7:0] cbuf_r [4];
  logic [7:0] cbuf_nxt [4];
  logic [7:0] cbuf_shift [4];
  logic [2:0] fill_r, fill_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       last_r, last_nxt;

  // byte held back until the next one or the end of the step is known
  logic [7:0] pend_r, pend_nxt;
  logic       pend_vld_r, pend_vld_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_present_r, out_present_nxt;
  logic       out_last_r, out_last_nxt;

  // front character decode
  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  exp_len;
  logic [20:0] cp;
  logic        dec_ok;
  logic        raw_mode;
  logic        is_ctrl, is_ws, is_cjk;
  logic [2:0]  n_emit;
  logic [2:0]  drop_n;
  logic [7:0]  emit_byte;
  logic [2:0]  cjk_sel;
  logic        out_free;

  function automatic logic is_cont(input logic [7:0] x);
    return x[7:6] == 2'b10;
  endfunction

  assign b0 = cbuf_r[0];
  assign b1 = cbuf_r[1];
  assign b2 = cbuf_r[2];
  assign b3 = cbuf_r[3];
  assign raw_mode = !clean_r && !cjk_r;

  // lead length and strict decode
  always_comb begin
    if (!b0[7])                    exp_len = 3'd1;
    else if (b0[7:5] == 3'b110)    exp_len = 3'd2;
    else if (b0[7:4] == 4'b1110)   exp_len = 3'd3;
    else if (b0[7:3] == 5'b11110)  exp_len = 3'd4;
    else                           exp_len = 3'd1;

    cp     = {13'd0, b0};
    dec_ok = 1'b0;
    case (exp_len)
      3'd1: begin
        cp     = {13'd0, b0};
        dec_ok = !b0[7];
      end
      3'd2: begin
        cp     = {10'd0, b0[4:0], b1[5:0]};
        dec_ok = (b0 >= 8'hC2) && is_cont(b1);
      end
      3'd3: begin
        cp     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        dec_ok = is_cont(b1) && is_cont(b2)
                 && !(b0 == 8'hE0 && b1 < 8'hA0)
                 && !(b0 == 8'hED && b1 > 8'h9F);
      end
      3'd4: begin
        cp     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        dec_ok = (b0 <= 8'hF4) && is_cont(b1) && is_cont(b2) && is_cont(b3)
                 && !(b0 == 8'hF0 && b1 < 8'h90)
                 && !(b0 == 8'hF4 && b1 > 8'h8F);
      end
      default: begin
        cp     = {13'd0, b0};
        dec_ok = 1'b0;
      end
    endcase
  end

  // character classes
  always_comb begin
    is_ws   = clean_r && (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D);
    is_ctrl = clean_r && ((cp < 21'h20 && !(cp == 21'h09 || cp == 21'h0A || cp == 21'h0D))
                          || cp == 21'h7F
                          || (cp >= 21'h80 && cp <= 21'h9F));
    is_cjk  = cjk_r && ((cp >= 21'h04E00 && cp <= 21'h09FFF)
                        || (cp >= 21'h03400 && cp <= 21'h04DBF)
                        || (cp >= 21'h20000 && cp <= 21'h2A6DF)
                        || (cp >= 21'h2A700 && cp <= 21'h2EBEF)
                        || (cp >= 21'h0F900 && cp <= 21'h0FAFF)
                        || (cp >= 21'h2F800 && cp <= 21'h2FA1F));
  end

  // emission plan for the front character
  always_comb begin
    cjk_sel   = idx_r - 3'd1;
    n_emit    = 3'd0;
    drop_n    = 3'd1;
    emit_byte = b0;
    if (raw_mode || !dec_ok) begin
      n_emit    = (raw_mode || !clean_r) ? 3'd1 : 3'd0;
      drop_n    = 3'd1;
      emit_byte = b0;
    end else if (is_ctrl) begin
      n_emit = 3'd0;
      drop_n = exp_len;
    end else if (is_ws) begin
      n_emit    = 3'd1;
      drop_n    = exp_len;
      emit_byte = SPACE;
    end else if (is_cjk) begin
      n_emit = exp_len + 3'd2;
      drop_n = exp_len;
      if (idx_r == 3'd0 || idx_r == exp_len + 3'd1) emit_byte = SPACE;
      else emit_byte = cbuf_r[cjk_sel[1:0]];
    end else begin
      n_emit    = exp_len;
      drop_n    = exp_len;
      emit_byte = cbuf_r[idx_r[1:0]];
    end
  end

  // buffer after dropping the front character
  always_comb begin
    cbuf_shift = cbuf_r;
    case (drop_n)
      3'd1: begin
        cbuf_shift[0] = cbuf_r[1];
        cbuf_shift[1] = cbuf_r[2];
        cbuf_shift[2] = cbuf_r[3];
      end
      3'd2: begin
        cbuf_shift[0] = cbuf_r[2];
        cbuf_shift[1] = cbuf_r[3];
      end
      3'd3: begin
        cbuf_shift[0] = cbuf_r[3];
      end
      default: cbuf_shift = cbuf_r;
    endcase
  end

  // status
  assign out_free = !out_valid_r || out_ready;
  always_comb begin
    stat.more    = (fill_r != 3'd0) && (raw_mode || fill_r >= exp_len);
    stat.step_ok = (n_emit == 3'd0) || !pend_vld_r || out_free;
    stat.fin_ok  = !(pend_vld_r || last_r) || out_free;
  end

  // next values
  always_comb begin
    cbuf_nxt        = cbuf_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    last_nxt        = last_r;
    pend_nxt        = pend_r;
    pend_vld_nxt    = pend_vld_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_byte_nxt    = out_byte_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;

    // take the accepted byte
    if (cmd.load) begin
      cbuf_nxt[fill_r[1:0]] = in_byte;
      fill_nxt              = fill_r + 3'd1;
      last_nxt              = in_last;
      idx_nxt               = 3'd0;
    end

    // one emission or drop
    if (cmd.step) begin
      if (n_emit != 3'd0) begin
        if (pend_vld_r) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = pend_r;
          out_present_nxt = 1'b1;
          out_last_nxt    = 1'b0;
        end
        pend_nxt     = emit_byte;
        pend_vld_nxt = 1'b1;
      end
      if (n_emit == 3'd0 || idx_r == n_emit - 3'd1) begin
        cbuf_nxt = cbuf_shift;
        fill_nxt = fill_r - drop_n;
        idx_nxt  = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end

    // close the step
    if (cmd.finish) begin
      if (pend_vld_r) begin
        out_valid_nxt   = 1'b1;
        out_byte_nxt    = pend_r;
        out_present_nxt = 1'b1;
        out_last_nxt    = last_r;
        pend_vld_nxt    = 1'b0;
      end else if (last_r) begin
        out_valid_nxt   = 1'b1;
        out_byte_nxt    = 8'd0;
        out_present_nxt = 1'b0;
        out_last_nxt    = 1'b1;
      end
      if (last_r) fill_nxt = 3'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clean_r     <= 1'b1;
      cjk_r       <= 1'b1;
      fill_r      <= 3'd0;
      idx_r       <= 3'd0;
      last_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLEAN: clean_r <= cfg_data;
          REG_CJK:   cjk_r   <= cfg_data;
          default:   ;
        endcase
      end
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cbuf_r        <= cbuf_nxt;
    pend_r        <= pend_nxt;
    out_byte_r    <= out_byte_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_last         = out_last_r;

endmodule

FILE: bench/utcs_bench_pkg.sv
package utcs_bench_pkg;

  // configuration register indexes
  localparam logic REG_CLEAN_ENABLE = 1'b0;
  localparam logic REG_CJK_ENABLE   = 1'b1;

  // most result bytes that one input byte can release
  localparam int MAX_RESULTS = 6;

endpackage

FILE: bench/norm_stream_check.sv
module norm_stream_check
  import utcs_bench_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_byte_present,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  SPACE = 8'h20;
  localparam logic [20:0] CP_TAB = 21'h09;
  localparam logic [20:0] CP_LF  = 21'h0A;
  localparam logic [20:0] CP_CR  = 21'h0D;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } norm_byte_t;

  // predicted normaliser state and modes
  logic       clean_en;
  logic       cjk_en;
  logic [7:0] char_buf [4];
  logic [2:0] fill;
  logic [2:0] exp_len;

  norm_byte_t expected_bytes [$];
  norm_byte_t step_bytes [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // sequence length from the lead byte
  function automatic logic [2:0] lead_bytes(input logic [7:0] b);
    if (b < 8'h80) return 3'd1;
    if ((b & 8'hE0) == 8'hC0) return 3'd2;
    if ((b & 8'hF0) == 8'hE0) return 3'd3;
    if ((b & 8'hF8) == 8'hF0) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  // strict decode of the front character of the buffer
  function automatic logic decode_front(input logic [2:0] len, output logic [20:0] cp);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    b0 = char_buf[0];
    b1 = char_buf[1];
    b2 = char_buf[2];
    b3 = char_buf[3];
    cp = '0;
    case (len)
      3'd1: begin
        cp = {13'd0, b0};
        return b0 < 8'h80;
      end
      3'd2: begin
        cp = {10'd0, b0[4:0], b1[5:0]};
        return b0 >= 8'hC2 && is_cont(b1);
      end
      3'd3: begin
        cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        if (!is_cont(b1) || !is_cont(b2)) return 1'b0;
        if (b0 == 8'hE0 && b1 < 8'hA0) return 1'b0;
        if (b0 == 8'hED && b1 > 8'h9F) return 1'b0;
        return 1'b1;
      end
      default: begin
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        if (b0 > 8'hF4) return 1'b0;
        if (!is_cont(b1) || !is_cont(b2) || !is_cont(b3)) return 1'b0;
        if (b0 == 8'hF0 && b1 < 8'h90) return 1'b0;
        if (b0 == 8'hF4 && b1 > 8'h8F) return 1'b0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic is_ctrl(input logic [20:0] cp);
    if (cp == CP_TAB || cp == CP_LF || cp == CP_CR) return 1'b0;
    if (cp < 21'h20) return 1'b1;
    if (cp == 21'h7F) return 1'b1;
    return cp >= 21'h80 && cp <= 21'h9F;
  endfunction

  function automatic logic is_cjk(input logic [20:0] cp);
    return (cp >= 21'h4E00 && cp <= 21'h9FFF)
        || (cp >= 21'h3400 && cp <= 21'h4DBF)
        || (cp >= 21'h20000 && cp <= 21'h2A6DF)
        || (cp >= 21'h2A700 && cp <= 21'h2EBEF)
        || (cp >= 21'hF900 && cp <= 21'hFAFF)
        || (cp >= 21'h2F800 && cp <= 21'h2FA1F);
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    if (step_bytes.size() < MAX_RESULTS) step_bytes.push_back({v, 1'b1, 1'b0});
  endfunction

  // discard k bytes from the front and re-read the lead
  function automatic void drop_front(input int k);
    int i;
    if (k > fill) k = fill;
    for (i = 0; i + k < fill && i < 4; i++) char_buf[i] = char_buf[(i + k) % 4];
    fill    = fill - 3'(k);
    exp_len = (fill != 0) ? lead_bytes(char_buf[0]) : 3'd0;
  endfunction

  // expected output bytes for one accepted request
  task automatic predict_text_byte(input logic [7:0] b, input logic last);
    int          i;
    logic [2:0]  len;
    logic [20:0] cp;
    step_bytes.delete();
    if (!clean_en && !cjk_en) begin
      // plain pass-through, partial character flushed first
      for (i = 0; i < fill; i++) put_byte(char_buf[i]);
      put_byte(b);
      fill    = 3'd0;
      exp_len = 3'd0;
    end else begin
      if (fill == 0 || exp_len == 0 || exp_len > 4)
        exp_len = lead_bytes((fill != 0) ? char_buf[0] : b);
      if (fill < 4) begin
        char_buf[fill[1:0]] = b;
        fill = fill + 3'd1;
      end
      while (fill > 0 && fill >= exp_len) begin
        len = exp_len;
        if (decode_front(len, cp)) begin
          if (clean_en && is_ctrl(cp)) begin
            // control character removed
          end else if (clean_en && (cp == CP_TAB || cp == CP_LF || cp == CP_CR)) begin
            put_byte(SPACE);
          end else if (cjk_en && is_cjk(cp)) begin
            put_byte(SPACE);
            for (i = 0; i < len; i++) put_byte(char_buf[i]);
            put_byte(SPACE);
          end else begin
            for (i = 0; i < len; i++) put_byte(char_buf[i]);
          end
          drop_front(len);
        end else begin
          // bad lead: raw or removed, rest parsed again
          if (!clean_en) put_byte(char_buf[0]);
          drop_front(1);
        end
      end
      // truncated tail discarded at end of text
      if (last) begin
        fill    = 3'd0;
        exp_len = 3'd0;
      end
    end
    if (last) begin
      if (step_bytes.size() == 0) step_bytes.push_back({8'h00, 1'b0, 1'b1});
      else step_bytes[step_bytes.size() - 1].last = 1'b1;
    end
    foreach (step_bytes[k]) expected_bytes.push_back(step_bytes[k]);
  endtask

  // follow config writes, predict on input, compare on output
  always @(posedge clk) begin
    norm_byte_t want;
    if (!rst_n) begin
      clean_en = 1'b1;
      cjk_en   = 1'b1;
      for (int i = 0; i < 4; i++) char_buf[i] = 8'h00;
      fill    = 3'd0;
      exp_len = 3'd0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CLEAN_ENABLE) clean_en = cfg_data;
        else if (cfg_index == REG_CJK_ENABLE) cjk_en = cfg_data;
      end
      if (in_valid && in_ready) predict_text_byte(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %02h present %0b last %0b",
                 out_byte, out_byte_present, out_last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            fail_count++;
          end
          if (want.present !== out_byte_present) begin
            $error("out_byte_present: expected %0b, actual %0b", want.present,
                   out_byte_present);
            fail_count++;
          end
          if (want.last !== out_last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import utcs_pkg::*;
  import utcs_bench_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES  = 36;
  localparam int NUM_PHASES   = 8;

  // idle patterns
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECV   = 2;
  localparam int IDLE_BOTH   = 3;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_present;
  logic       out_last;

  int fail_count;
  int pending;
  int idle_mode;
  int hold_reqs;
  int hold_served;
  int stall_cycles;

  logic [7:0] text_q [$];

  utf8_text_clean_cjk_spacer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_last         (out_last)
  );

  norm_stream_check u_norm_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 38;
    return 1'b0;
  endfunction

  function automatic bit recv_stalls();
    if (idle_mode == IDLE_RECV) return $urandom_range(99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 38;
    return 1'b0;
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    out_ready   = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= !recv_stalls();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // utf-8 encoding of one codepoint
  function automatic void encode_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_q.push_back({3'b110, cp[10:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_q.push_back({4'b1110, cp[15:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else begin
      text_q.push_back({5'b11110, cp[20:18]});
      text_q.push_back({2'b10, cp[17:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // one character of assorted class, mostly well formed
  function automatic void gen_char();
    int          sel;
    int          lo;
    int          hi;
    logic [20:0] cp;
    sel = $urandom_range(99);
    if (sel < 25) begin
      text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (sel < 33) begin
      if ($urandom_range(7) == 0) text_q.push_back(8'h7F);
      else text_q.push_back(8'($urandom_range(8'h1F)));
    end else if (sel < 43) begin
      encode_cp(21'($urandom_range(21'h80, 21'h7FF)));
    end else if (sel < 53) begin
      encode_cp(21'($urandom_range(21'h800, 21'hFFFF)));
    end else if (sel < 68) begin
      case ($urandom_range(5))
        0:       begin lo = 'h3400;  hi = 'h4DBF;  end
        1:       begin lo = 'h4E00;  hi = 'h9FFF;  end
        2:       begin lo = 'hF900;  hi = 'hFAFF;  end
        3:       begin lo = 'h20000; hi = 'h2A6DF; end
        4:       begin lo = 'h2A700; hi = 'h2EBEF; end
        default: begin lo = 'h2F800; hi = 'h2FA1F; end
      endcase
      case ($urandom_range(5))
        0:       cp = 21'(lo - 1);
        1:       cp = 21'(hi + 1);
        2:       cp = 21'(lo);
        3:       cp = 21'(hi);
        default: cp = 21'($urandom_range(lo, hi));
      endcase
      encode_cp(cp);
    end else if (sel < 76) begin
      encode_cp(21'($urandom_range(21'h10000, 21'h10FFFF)));
    end else if (sel < 88) begin
      text_q.push_back(8'($urandom_range(255)));
    end else begin
      // broken sequences
      case ($urandom_range(3))
        0: begin
          encode_cp(21'($urandom_range(21'h80, 21'h10FFFF)));
          void'(text_q.pop_back());
        end
        1: begin
          encode_cp(21'($urandom_range(21'h80, 21'h10FFFF)));
          text_q[text_q.size() - 1] = 8'($urandom_range(255));
        end
        2: begin
          // overlong forms
          case ($urandom_range(2))
            0: text_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
            1: begin
              text_q.push_back(8'hE0);
              text_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
            end
            default: begin
              text_q.push_back(8'hF0);
              text_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
              text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
          endcase
          text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          // surrogates, beyond U+10FFFF, leads F5..FF
          case ($urandom_range(2))
            0: text_q.push_back(8'hED);
            1: text_q.push_back(8'hF4);
            default: text_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
          endcase
          text_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
          text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
          text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end
  endfunction

  // one request, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    in_valid <= 1'b0;
    text_q.delete();
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // both mode registers, back to back
  task automatic set_modes(input logic clean, input logic cjk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CLEAN_ENABLE;
    cfg_data  <= clean;
    @(negedge clk);
    cfg_index <= REG_CJK_ENABLE;
    cfg_data  <= cjk;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int sent;
    int nchars;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_CLEAN_ENABLE;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    in_last      = 1'b0;
    idle_mode    = IDLE_NONE;
    hold_reqs    = 0;
    stall_cycles = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset modes: controls, tab, c1 range, ideographs, bad leads
    text_q = '{8'h41, 8'h00, 8'h09, 8'h7F, 8'hC2, 8'h80, 8'hE4, 8'hB8, 8'h80,
               8'hFF, 8'hC0, 8'h41, 8'hF0, 8'hA0, 8'h80, 8'h80};
    send_text();
    // top codepoint, surrogate, truncated tail giving a bare end marker
    text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90};
    send_text();
    // line feed alone becomes a final space
    text_q = '{8'h0A};
    send_text();

    // random phases over every mode pair and idle pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if (ph < 4) set_modes(!ph[1], !ph[0]);
      else set_modes(1'($urandom_range(1)), 1'($urandom_range(1)));
      idle_mode = ph % 4;
      if (ph == 4) hold_reqs++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        nchars = $urandom_range(1, 8);
        repeat (nchars) gen_char();
        sent += text_q.size();
        send_text();
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
